[rtl/core/mqd_pkg.sv]
package mqd_pkg;

  localparam int PIX_COUNT = 4;
  localparam int CHAN_COUNT = 4;
  localparam int PIX_W = 32;
  localparam int SUM_W = 10;
  localparam int KEY_W = 24;
  localparam int FIELD_W = 4;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_KEY = 2'd1;
  localparam logic [1:0] MODE_ARGB = 2'd2;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_KEY_COLOR = 3'd1;
  localparam logic [2:0] CFG_RED_WIDTH = 3'd2;
  localparam logic [2:0] CFG_GREEN_WIDTH = 3'd3;
  localparam logic [2:0] CFG_BLUE_WIDTH = 3'd4;
  localparam logic [2:0] CFG_ALPHA_WIDTH = 3'd5;

  // floor(x / 3) == (x * 683) >> 11 for x up to 765
  localparam logic [SUM_W-1:0] DIV3_MUL = 10'd683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W = 2 * SUM_W;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } mqd_stage_en_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic keyed;
  } mqd_avg_t;

endpackage

[rtl/core/mqd_average.sv]
module mqd_average (
  input  logic                                    clk,
  input  mqd_pkg::mqd_stage_en_t                  en,
  input  logic [mqd_pkg::PIX_COUNT*mqd_pkg::PIX_W-1:0] quad,
  input  logic [1:0]                              mode,
  input  logic [mqd_pkg::KEY_W-1:0]               key_color,
  output mqd_pkg::mqd_avg_t                       result
);
  import mqd_pkg::*;

  logic [PIX_COUNT-1:0] match;
  logic [SUM_W-1:0]     sum_next [CHAN_COUNT];
  logic [2:0]           kept_next;

  logic [SUM_W-1:0]     s1_sum [CHAN_COUNT];
  logic [2:0]           s1_kept;

  logic [SUM_W-1:0]     s2_sum [CHAN_COUNT];
  logic [PROD_W-1:0]    s2_prod [CHAN_COUNT];
  logic [2:0]           s2_kept;

  logic [PIX_W-1:0]     avg_next;
  logic                 keyed_next;

  // stage 1: key match, masked channel sums, kept count
  always_comb begin
    // key register holds red high, pixels hold red in byte 0
    for (int i = 0; i < PIX_COUNT; i++) begin
      match[i] = (mode == MODE_KEY) &&
                 (quad[PIX_W*i +: KEY_W] ==
                  {key_color[7:0], key_color[15:8], key_color[23:16]});
    end
    kept_next = 3'd4 - 3'($countones(match));
    for (int k = 0; k < CHAN_COUNT; k++) begin
      sum_next[k] = '0;
      for (int i = 0; i < PIX_COUNT; i++) begin
        if (!match[i]) begin
          sum_next[k] = sum_next[k] + SUM_W'(quad[PIX_W*i + 8*k +: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_sum  <= sum_next;
      s1_kept <= kept_next;
    end
  end

  // stage 2: reciprocal multiply for a three-pixel average
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int k = 0; k < CHAN_COUNT; k++) begin
        s2_prod[k] <= s1_sum[k] * DIV3_MUL;
      end
      s2_sum  <= s1_sum;
      s2_kept <= s1_kept;
    end
  end

  // stage 3: pick the average for the mode and kept count
  always_comb begin
    avg_next   = '0;
    keyed_next = 1'b0;
    if (mode == MODE_KEY) begin
      case (s2_kept)
        3'd2: begin
          for (int k = 0; k < 3; k++) avg_next[8*k +: 8] = s2_sum[k][8:1];
        end
        3'd3: begin
          for (int k = 0; k < 3; k++) avg_next[8*k +: 8] = s2_prod[k][DIV3_SHIFT +: 8];
        end
        3'd4: begin
          for (int k = 0; k < 3; k++) avg_next[8*k +: 8] = s2_sum[k][9:2];
        end
        default: begin
          // key colour wins the quad
          avg_next[KEY_W-1:0] = {key_color[7:0], key_color[15:8], key_color[23:16]};
          keyed_next = 1'b1;
        end
      endcase
    end else begin
      for (int k = 0; k < 3; k++) avg_next[8*k +: 8] = s2_sum[k][9:2];
      if (mode == MODE_ARGB) avg_next[31:24] = s2_sum[3][9:2];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      result.pixel <= avg_next;
      result.keyed <= keyed_next;
    end
  end

endmodule

[rtl/core/mipmap_quad_downsampler.sv]
// 2x2 box filter for mip generation: one pixel quad enters per clock and its averaged pixel,
// 16-bit packed form and keyed flag leave through four register stages (masked sums,
// reciprocal multiply for three-pixel averages, average select, packing into the output
// register). Throughput is one quad per cycle whenever the output is taken; a stall on
// the output side holds the pipeline while empty stages keep filling. Configuration
// registers are read live, so change them only while no quad is in flight.
module mipmap_quad_downsampler (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [2:0]                              cfg_index,
  input  logic [mqd_pkg::KEY_W-1:0]               cfg_data,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // top_left, top_right, bottom_left, bottom_right
  input  logic [mqd_pkg::PIX_COUNT*mqd_pkg::PIX_W-1:0] s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // average_pixel [31:0], packed_color [47:32]
  output logic [47:0]                             m_tdata,
  // was_keyed
  output logic                                    m_tuser
);
  import mqd_pkg::*;

  logic [1:0]         mode;
  logic [KEY_W-1:0]   key_color;
  logic [FIELD_W-1:0] red_width;
  logic [FIELD_W-1:0] green_width;
  logic [FIELD_W-1:0] blue_width;
  logic [FIELD_W-1:0] alpha_width;

  logic [3:1]         stage_valid;
  logic [4:1]         stage_rdy;
  mqd_stage_en_t      en;
  mqd_avg_t           avg;

  logic [FIELD_W-1:0] nr, ng, nb, na;
  logic [7:0]         ch_a, ch_r, ch_g, ch_b;
  logic [7:0]         top_a, top_r, top_g, top_b;
  logic [31:0]        packed_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      key_color   <= '0;
      red_width   <= 4'd5;
      green_width <= 4'd6;
      blue_width  <= 4'd5;
      alpha_width <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:        mode        <= cfg_data[1:0];
        CFG_KEY_COLOR:   key_color   <= cfg_data;
        CFG_RED_WIDTH:   red_width   <= cfg_data[FIELD_W-1:0];
        CFG_GREEN_WIDTH: green_width <= cfg_data[FIELD_W-1:0];
        CFG_BLUE_WIDTH:  blue_width  <= cfg_data[FIELD_W-1:0];
        CFG_ALPHA_WIDTH: alpha_width <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when empty or when its item moves on
  assign stage_rdy[4] = m_tready || !m_tvalid;
  assign stage_rdy[3] = !stage_valid[3] || stage_rdy[4];
  assign stage_rdy[2] = !stage_valid[2] || stage_rdy[3];
  assign stage_rdy[1] = !stage_valid[1] || stage_rdy[2];
  assign s_tready = stage_rdy[1];
  assign en = '{s1: stage_rdy[1], s2: stage_rdy[2], s3: stage_rdy[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (stage_rdy[1]) stage_valid[1] <= s_tvalid;
      if (stage_rdy[2]) stage_valid[2] <= stage_valid[1];
      if (stage_rdy[3]) stage_valid[3] <= stage_valid[2];
      if (stage_rdy[4]) m_tvalid       <= stage_valid[3];
    end
  end

  mqd_average u_average (
    .clk       (clk),
    .en        (en),
    .quad      (s_tdata),
    .mode      (mode),
    .key_color (key_color),
    .result    (avg)
  );

  // stage 4: pack the averaged channels into 16 bits
  always_comb begin
    nr = (red_width   > 4'd8) ? 4'd8 : red_width;
    ng = (green_width > 4'd8) ? 4'd8 : green_width;
    nb = (blue_width  > 4'd8) ? 4'd8 : blue_width;
    na = (alpha_width > 4'd8) ? 4'd8 : alpha_width;
    if (mode == MODE_ARGB) begin
      ch_a = avg.pixel[7:0];
      ch_r = avg.pixel[15:8];
      ch_g = avg.pixel[23:16];
      ch_b = avg.pixel[31:24];
    end else begin
      ch_a = 8'd0;
      ch_r = avg.pixel[7:0];
      ch_g = avg.pixel[15:8];
      ch_b = avg.pixel[23:16];
    end
    top_r = ch_r >> (4'd8 - nr);
    top_g = ch_g >> (4'd8 - ng);
    top_b = ch_b >> (4'd8 - nb);
    // alpha reads all ones for a kept chroma-key quad
    if (mode == MODE_KEY) top_a = 8'hFF >> (4'd8 - na);
    else                  top_a = ch_a >> (4'd8 - na);
    packed_wide = {24'd0, top_b}
                | ({24'd0, top_g} << nb)
                | ({24'd0, top_r} << (5'(nb) + 5'(ng)))
                | ({24'd0, top_a} << (5'(nb) + 5'(ng) + 5'(nr)));
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[4]) begin
      m_tdata[31:0]  <= avg.pixel;
      m_tdata[47:32] <= avg.keyed ? 16'd0 : packed_wide[15:0];
      m_tuser        <= avg.keyed;
    end
  end

  a_keyed_packs_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[47:32] == 16'd0)
    else $error("keyed item with nonzero packed color");

  a_keyed_only_chroma : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> mode == MODE_KEY)
    else $error("keyed item outside chroma-key mode");

  a_byte3_argb_only : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && mode != MODE_ARGB |-> m_tdata[31:24] == 8'd0)
    else $error("nonzero top byte outside argb mode");

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> stage_valid[1])
    else $error("accepted item missing from first stage");

endmodule

[tb/mipmap_quad_downsampler_test.sv]
module mipmap_quad_downsampler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mqd_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 60000;
  localparam int IDLE_PCT = 13;

  typedef struct packed {
    logic [31:0] avg_pixel;
    logic [15:0] color16;
    logic        keyed;
  } quad_avg_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = CFG_MODE;
  logic [23:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic         m_tuser;

  // register copies, written together with the block's registers
  logic [1:0]  mode_now = MODE_PLAIN;
  logic [23:0] key_now = '0;
  logic [3:0]  red_w = 4'd5;
  logic [3:0]  green_w = 4'd6;
  logic [3:0]  blue_w = 4'd5;
  logic [3:0]  alpha_w = 4'd0;

  logic [127:0] pending_quads[$];
  quad_avg_t    expected_avgs[$];
  logic         took_item = 1'b0;
  bit           calm = 1'b0;
  int           errors = 0;
  int           cycles = 0;
  int           accepted_quads = 0;
  int           checked_avgs = 0;
  int           keyed_avgs = 0;
  int           settings_run = 0;

  mipmap_quad_downsampler dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // key register holds red high, pixels hold red in byte 0
  function automatic logic [23:0] key_pixel(logic [23:0] key);
    return {key[7:0], key[15:8], key[23:16]};
  endfunction

  function automatic logic [63:0] top_of(logic [7:0] c, int n);
    if (n == 0) return '0;
    return 64'(c >> (8 - n));
  endfunction

  function automatic logic [15:0] pack_color(logic [7:0] a, bit a_ones, logic [7:0] r,
                                             logic [7:0] g, logic [7:0] b);
    int nb;
    int ng;
    int nr;
    int na;
    logic [63:0] av;
    logic [63:0] v;
    nb = (blue_w > 4'd8) ? 8 : int'(blue_w);
    ng = (green_w > 4'd8) ? 8 : int'(green_w);
    nr = (red_w > 4'd8) ? 8 : int'(red_w);
    na = (alpha_w > 4'd8) ? 8 : int'(alpha_w);
    av = a_ones ? ((64'd1 << na) - 64'd1) : top_of(a, na);
    v = top_of(b, nb) | (top_of(g, ng) << nb) | (top_of(r, nr) << (nb + ng))
        | (av << (nb + ng + nr));
    return v[15:0];
  endfunction

  function automatic quad_avg_t downsample_quad(logic [127:0] quad);
    quad_avg_t res;
    int sum[4];
    logic [7:0] avg[4];
    int kept;
    int dropped;
    res = '0;
    kept = 0;
    dropped = 0;
    for (int k = 0; k < 4; k++) begin
      sum[k] = 0;
      avg[k] = '0;
    end
    if (mode_now == MODE_KEY) begin
      for (int i = 0; i < 4; i++) begin
        if (quad[32*i +: 24] == key_pixel(key_now)) begin
          dropped++;
        end else begin
          for (int k = 0; k < 3; k++) sum[k] += quad[32*i + 8*k +: 8];
          kept++;
        end
      end
      if (dropped > kept || kept == 0) begin
        res.avg_pixel = {8'h00, key_pixel(key_now)};
        res.keyed = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) avg[k] = 8'(sum[k] / kept);
        res.avg_pixel = {8'h00, avg[2], avg[1], avg[0]};
        res.color16 = pack_color(8'h00, 1'b1, avg[0], avg[1], avg[2]);
      end
    end else if (mode_now == MODE_ARGB) begin
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 4; k++) sum[k] += quad[32*i + 8*k +: 8];
      for (int k = 0; k < 4; k++) avg[k] = 8'(sum[k] >> 2);
      res.avg_pixel = {avg[3], avg[2], avg[1], avg[0]};
      res.color16 = pack_color(avg[0], 1'b0, avg[1], avg[2], avg[3]);
    end else begin
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 3; k++) sum[k] += quad[32*i + 8*k +: 8];
      for (int k = 0; k < 3; k++) avg[k] = 8'(sum[k] >> 2);
      res.avg_pixel = {8'h00, avg[2], avg[1], avg[0]};
      res.color16 = pack_color(8'h00, 1'b0, avg[0], avg[1], avg[2]);
    end
    return res;
  endfunction

  // in key mode about half the pixels are the key or one bit away from it
  function automatic logic [127:0] random_quad(bit keying);
    logic [127:0] quad;
    logic [31:0] px;
    int sel;
    for (int i = 0; i < 4; i++) begin
      sel = $urandom_range(0, 9);
      px = $urandom;
      if (keying && sel < 4)
        px[23:0] = key_pixel(key_now);
      else if (keying && sel == 4)
        px[23:0] = key_pixel(key_now) ^ (24'd1 << $urandom_range(0, 23));
      else if (sel == 5)
        px = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      quad[32*i +: 32] = px;
    end
    return quad;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_MODE:        mode_now = val[1:0];
      CFG_KEY_COLOR:   key_now = val;
      CFG_RED_WIDTH:   red_w = val[3:0];
      CFG_GREEN_WIDTH: green_w = val[3:0];
      CFG_BLUE_WIDTH:  blue_w = val[3:0];
      CFG_ALPHA_WIDTH: alpha_w = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_setting(input logic [1:0] mode, input logic [23:0] key,
                             input logic [3:0] rw, input logic [3:0] gw,
                             input logic [3:0] bw, input logic [3:0] aw,
                             input bit directed, input int n_random);
    logic [31:0] filler;
    set_reg(CFG_MODE, {22'd0, mode});
    set_reg(CFG_KEY_COLOR, key);
    set_reg(CFG_RED_WIDTH, {20'd0, rw});
    set_reg(CFG_GREEN_WIDTH, {20'd0, gw});
    set_reg(CFG_BLUE_WIDTH, {20'd0, bw});
    set_reg(CFG_ALPHA_WIDTH, {20'd0, aw});
    settings_run++;
    @(posedge clk);
    if (directed) begin
      if (mode == MODE_KEY) begin
        // zero to four pixels keyed; two keyed is a tie and still averages
        for (int n = 0; n <= 4; n++) begin
          logic [127:0] quad;
          for (int i = 0; i < 4; i++) begin
            filler = $urandom;
            quad[32*i +: 32] = (i < n) ? {filler[31:24], key_pixel(key)}
                                       : {filler[31:24], ~key_pixel(key) ^ filler[23:0]};
            if (i >= n && quad[32*i +: 24] == key_pixel(key)) quad[32*i] = ~quad[32*i];
          end
          pending_quads.push_back(quad);
        end
        pending_quads.push_back({4{8'h00, key_pixel(key) ^ 24'h000001}});
      end else begin
        pending_quads.push_back('0);
        pending_quads.push_back({128{1'b1}});
        // rounding down: three full bytes and one empty
        pending_quads.push_back({32'h0000_0000, {3{32'hFFFF_FFFF}}});
        pending_quads.push_back({4{32'hAA55_FF01}});
      end
    end
    for (int j = 0; j < n_random; j++) pending_quads.push_back(random_quad(mode == MODE_KEY));
    // drain before the next register write
    do @(negedge clk); while (pending_quads.size() != 0 || expected_avgs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // driver: hold an offered item until it is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !took_item) begin
      s_tvalid <= 1'b1;
    end else if (pending_quads.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
      s_tvalid <= 1'b1;
      s_tdata <= pending_quads[0];
    end else begin
      s_tvalid <= 1'b0;
    end
    m_tready <= !rst && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // monitor: check results in order, then predict for the item taken at this edge
  always @(posedge clk) begin
    quad_avg_t want;
    took_item <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_avgs.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          want = expected_avgs.pop_front();
          checked_avgs++;
          if (want.keyed) keyed_avgs++;
          if (m_tdata[31:0] !== want.avg_pixel)
            report_mismatch($sformatf("average_pixel %h, want %h", m_tdata[31:0],
                                      want.avg_pixel));
          if (m_tdata[47:32] !== want.color16)
            report_mismatch($sformatf("packed_color %h, want %h", m_tdata[47:32],
                                      want.color16));
          if (m_tuser !== want.keyed)
            report_mismatch($sformatf("was_keyed %b, want %b", m_tuser, want.keyed));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_avgs.push_back(downsample_quad(s_tdata));
        void'(pending_quads.pop_front());
        accepted_quads++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_avgs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset packing (5/6/5, no alpha) before any write
    @(posedge clk);
    pending_quads.push_back({32'h1234_5678, 32'h00FF_00FF, 32'hFF00_FF00, 32'h8080_8080});
    do @(negedge clk); while (pending_quads.size() != 0 || expected_avgs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    run_setting(MODE_PLAIN, 24'h000000, 4'd5, 4'd6, 4'd5, 4'd0, 1'b1, 40);
    run_setting(MODE_ARGB, 24'hFFFFFF, 4'd4, 4'd4, 4'd4, 4'd4, 1'b1, 60);
    calm = 1'b1;
    run_setting(MODE_KEY, 24'hFF00FF, 4'd5, 4'd5, 4'd5, 4'd1, 1'b1, 80);
    calm = 1'b0;
    run_setting(MODE_SPARE, 24'h123456, 4'd8, 4'd8, 4'd8, 4'd8, 1'b0, 40);
    run_setting(MODE_KEY, 24'h000000, 4'd15, 4'd0, 4'd15, 4'd15, 1'b0, 50);
    run_setting(MODE_ARGB, 24'h000000, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 40);
    run_setting(MODE_KEY, 24'hFFFFFF, 4'd0, 4'd8, 4'd3, 4'd9, 1'b0, 40);
    for (int p = 0; p < 6; p++)
      run_setting(2'($urandom_range(0, 3)), 24'($urandom), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 1'b0, 20);

    if (expected_avgs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_avgs.size()));
    $display("%0d quads sent over %0d register settings, all four modes", accepted_quads,
             settings_run);
    $display("%0d averages checked, %0d of them keyed, in %0d cycles", checked_avgs,
             keyed_avgs, cycles);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
